[hw/rtl/nra_pkg.sv]
// Package for the node registry with aging: payload types, status codes
// and default constants. No dependencies.
package nra_pkg;
  localparam int TableDepthDef = 16;
  localparam logic [19:0] AgeLimitReset = 20'd10000;

  localparam logic [2:0] ST_REFRESHED = 3'd0;
  localparam logic [2:0] ST_INSERTED  = 3'd1;
  localparam logic [2:0] ST_DROPPED   = 3'd2;
  localparam logic [2:0] ST_REPORT    = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  typedef struct packed {
    logic        func;
    logic [47:0] mac_address;
    logic [31:0] node_id;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] report_id;
    logic [19:0] report_age_ms;
    logic        last;
  } out_item_t;
endpackage

[hw/rtl/nra_ram.sv]
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module nra_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/node_registry_with_aging.sv]
// Node registry with aging. Depends on nra_pkg and nra_ram.
// One item at a time. A sighting searches the N entries, compacts all N
// when the table is full, then appends; a query makes one memory read per
// entry through the single read port of the entry RAM, whose read data is
// registered; a stalled receiver holds the query walk.
// Reset (synchronous, rst_n low) clears the count, alive bits and
// age limit (10000); entry RAM contents stay undefined until written.
module node_registry_with_aging #(
  parameter int TableDepth = nra_pkg::TableDepthDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  nra_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output nra_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [19:0]        cfg_data
);
  localparam int AW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CW = $clog2(TableDepth + 1);
  localparam int EW = 48 + 32 + 32;
  localparam logic [CW-1:0] FULL = CW'(TableDepth);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRCH = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_APP  = 3'd3;
  localparam logic [2:0] S_QRY  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]            state_r, state_nxt;
  nra_pkg::in_item_t     item_r;
  logic [19:0]           limit_r;
  logic [CW-1:0]         count_r, count_nxt;
  logic [TableDepth-1:0] alive_r, alive_nxt;
  logic [CW-1:0]         rd_r, rd_nxt;
  logic [CW-1:0]         wr_r, wr_nxt;
  logic [AW-1:0]         pidx_r, pidx_nxt;
  logic                  hold_r, hold_nxt;
  nra_pkg::out_item_t    held_r, held_nxt;
  logic                  ov_r, ov_nxt;
  nra_pkg::out_item_t    od_r, od_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  nra_ram #(.Width(EW), .Depth(TableDepth), .AddrW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [47:0] e_addr;
  logic [31:0] e_id, e_time, age;
  logic        in_lim, out_free;
  assign e_addr   = rdata[EW-1 -: 48];
  assign e_id     = rdata[63:32];
  assign e_time   = rdata[31:0];
  assign age      = item_r.now_ms - e_time;
  assign in_lim   = age <= {12'd0, limit_r};
  assign out_free = !ov_r || out_ready;

  assign in_ready  = (state_r == S_IDLE) && !ov_r;
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    alive_nxt = alive_r;
    rd_nxt    = rd_r;
    wr_nxt    = wr_r;
    pidx_nxt  = pidx_r;
    hold_nxt  = hold_r;
    held_nxt  = held_r;
    ov_nxt    = ov_r && !out_ready;
    od_nxt    = od_r;
    we        = 1'b0;
    waddr     = wr_r[AW-1:0];
    wdata     = rdata;
    raddr     = rd_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          rd_nxt   = '0;
          wr_nxt   = '0;
          hold_nxt = 1'b0;
          raddr    = '0;
          if (in_data.func) begin
            state_nxt = S_QRY;
          end else begin
            state_nxt = S_SRCH;
          end
          if (count_r == '0) begin
            if (in_data.func) begin
              state_nxt = S_OUT;
              held_nxt  = '{nra_pkg::ST_EMPTY, 32'd0, 20'd0, 1'b1};
            end else begin
              state_nxt = S_APP;
            end
          end else begin
            rd_nxt = CW'(1);
          end
          pidx_nxt = '0;
        end
      end
      S_SRCH: begin
        pidx_nxt = rd_r[AW-1:0];
        if (e_addr == item_r.mac_address) begin
          we       = 1'b1;
          waddr    = pidx_r;
          wdata    = {item_r.mac_address, item_r.node_id, item_r.now_ms};
          alive_nxt[pidx_r] = 1'b1;
          held_nxt = '{nra_pkg::ST_REFRESHED, item_r.node_id, 20'd0, 1'b1};
          state_nxt = S_OUT;
        end else if (CW'(pidx_r) + CW'(1) >= count_r) begin
          if (count_r >= FULL) begin
            state_nxt = S_CMP;
            rd_nxt    = CW'(1);
            raddr     = '0;
            pidx_nxt  = '0;
          end else begin
            state_nxt = S_APP;
          end
        end else begin
          rd_nxt = rd_r + CW'(1);
        end
      end
      S_CMP: begin
        pidx_nxt = rd_r[AW-1:0];
        if (alive_r[pidx_r] && in_lim) begin
          we    = 1'b1;
          waddr = wr_r[AW-1:0];
          alive_nxt[wr_r[AW-1:0]] = 1'b1;
          wr_nxt = wr_r + CW'(1);
        end
        if (CW'(pidx_r) + CW'(1) >= count_r) begin
          count_nxt = (alive_r[pidx_r] && in_lim) ? wr_r + CW'(1) : wr_r;
          state_nxt = S_APP;
        end else begin
          rd_nxt = rd_r + CW'(1);
        end
      end
      S_APP: begin
        if (count_r < FULL) begin
          we    = 1'b1;
          waddr = count_r[AW-1:0];
          wdata = {item_r.mac_address, item_r.node_id, item_r.now_ms};
          alive_nxt[count_r[AW-1:0]] = 1'b1;
          count_nxt = count_r + CW'(1);
          held_nxt  = '{nra_pkg::ST_INSERTED, item_r.node_id, 20'd0, 1'b1};
        end else begin
          held_nxt  = '{nra_pkg::ST_DROPPED, 32'd0, 20'd0, 1'b1};
        end
        state_nxt = S_OUT;
      end
      S_QRY: begin
        if (out_free) begin
          pidx_nxt = rd_r[AW-1:0];
          if (!in_lim) begin
            alive_nxt[pidx_r] = 1'b0;
          end else begin
            if (hold_r) begin
              ov_nxt = 1'b1;
              od_nxt = held_r;
            end
            hold_nxt = 1'b1;
            held_nxt = '{nra_pkg::ST_REPORT, e_id, age[19:0], 1'b0};
          end
          if (CW'(pidx_r) + CW'(1) >= count_r) begin
            state_nxt = S_OUT;
            if (!in_lim && !hold_r) begin
              held_nxt = '{nra_pkg::ST_EMPTY, 32'd0, 20'd0, 1'b1};
            end else if (!in_lim) begin
              held_nxt.last = 1'b1;
            end else begin
              held_nxt.last = 1'b1;
            end
          end else begin
            rd_nxt = rd_r + CW'(1);
          end
        end else begin
          raddr = pidx_r;
        end
      end
      S_OUT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          od_nxt    = held_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      alive_r <= '0;
      limit_r <= nra_pkg::AgeLimitReset;
      ov_r    <= 1'b0;
      hold_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      alive_r <= alive_nxt;
      ov_r    <= ov_nxt;
      hold_r  <= hold_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid && in_ready) begin
      item_r <= in_data;
    end
    rd_r   <= rd_nxt;
    wr_r   <= wr_nxt;
    pidx_r <= pidx_nxt;
    held_r <= held_nxt;
    od_r   <= od_nxt;
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL)
    else $error("entry count beyond table depth");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_idle_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != S_IDLE)
    else $error("accepted item left no work");
`endif
endmodule
